@@ sv/top_k_sum_of_smaller_keys_assert.svh @@
// ----------------------------------------------------------------------------
// top_k_sum_of_smaller_keys_assert.svh
// assertion macros shared by the running top-k sum block
// ----------------------------------------------------------------------------
`ifndef TOP_K_SUM_OF_SMALLER_KEYS_ASSERT_SVH
`define TOP_K_SUM_OF_SMALLER_KEYS_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define TKS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// tks_pkg
// types and constants of the running top-k sum block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tks_pkg;

    // sizing
    localparam int MAX_K      = 64;
    localparam int VALUE_BITS = 20;
    localparam int KEY_W      = 20;
    localparam int VAL_W      = 20;
    localparam int IDX_W      = 16;
    localparam int KCFG_W     = 7;
    localparam int SUM_W      = 27;
    localparam int BEST_W     = 26;
    localparam int CNT_W      = $clog2(MAX_K + 1);

    // stream packing
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;

    localparam logic [VAL_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_APPEND,
        OP_REPLACE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic               clear;
        logic [VAL_W-1:0]   value;
    } cell_ctrl_t;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic               valid;
        logic               le;
        logic [VAL_W-1:0]   value;
    } cell_link_t;

endpackage

@@ sv/top_k_sum_of_smaller_keys.sv @@
// ----------------------------------------------------------------------------
// top_k_sum_of_smaller_keys
// running sum of the k largest values among items with a strictly smaller key
//
// usage
//   s_* carries one request per item: tdata holds key, value and index,
//   tuser[0] marks the first item of a data set (clears all kept state).
//   keys must arrive non-decreasing within a set; any key change opens a
//   new group, and all items of a group share the sum snapshot taken at
//   its first item.
//   m_* returns one result per item: the item's index and the saturated sum.
//   cfg_* writes k (keep_count) while the block is idle; it is always ready.
//   one item per cycle while results are taken: the sorted cell chain inserts a
//   value and drops the minimum in the same cycle, and the sum needs one add/subtract.
//   the result register is loaded when the input request is accepted.
//   when m_tready is low the result holds and s_tready follows it, so at
//   most one result waits; nothing is dropped.
//   reset empties the store, clears the sums and sets k to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_sum_of_smaller_keys import tks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // item_key, item_value, item_index
    input  logic [0:0]            s_tuser,   // first_of_set
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // result_index, best_sum, zero pad
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [KCFG_W-1:0]     cfg_data   // keep_count
);

    logic [KCFG_W-1:0]    keep_count_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]     snap_reg, snap_next;
    logic [KEY_W-1:0]     prev_key_reg;
    logic                 have_prev_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 s_accept;
    logic                 first;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     val;
    logic [IDX_W-1:0]     idx;
    logic [CNT_W-1:0]     keff;
    logic [CNT_W-1:0]     cnt_eff;
    logic [SUM_W-1:0]     sum_eff;
    logic [SUM_W-1:0]     snap_eff;
    logic                 new_group;
    logic                 do_append;
    logic                 do_replace;
    logic [BEST_W-1:0]    best;
    logic                 head_ok;
    cell_ctrl_t           ctrl;
    cell_link_t           cell_out [MAX_K];

    // unpack the request
    assign first = s_tuser[0];
    assign key   = s_tdata[KEY_W-1:0];
    assign val   = s_tdata[KEY_W+VAL_W-1:KEY_W] & VALUE_MASK;
    assign idx   = s_tdata[KEY_W+VAL_W+IDX_W-1:KEY_W+VAL_W];

    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // effective k saturates at the chain length
    always_comb
    begin
        if (32'(keep_count_reg) > 32'(MAX_K))
            keff = CNT_W'(MAX_K);
        else
            keff = CNT_W'(keep_count_reg);
    end

    // state as seen by this item, after an optional set start
    assign cnt_eff   = first ? '0 : count_reg;
    assign sum_eff   = first ? '0 : sum_reg;
    assign new_group = first | ~have_prev_reg | (key != prev_key_reg);
    assign snap_eff  = new_group ? sum_eff : snap_reg;
    assign best      = (snap_eff > SUM_W'(BEST_MAX)) ? BEST_MAX : snap_eff[BEST_W-1:0];

    // grow the store, or replace its minimum (cell 0) by a larger value
    assign do_append  = cnt_eff < keff;
    assign do_replace = ~do_append & (cnt_eff != '0) & (val > cell_out[0].value);

    always_comb
    begin
        ctrl.op    = OP_HOLD;
        ctrl.clear = s_accept & first;
        ctrl.value = val;
        count_next = count_reg;
        sum_next   = sum_reg;
        snap_next  = snap_reg;
        if (s_accept)
        begin
            count_next = cnt_eff;
            sum_next   = sum_eff;
            snap_next  = snap_eff;
            if (do_append)
            begin
                ctrl.op    = OP_APPEND;
                count_next = cnt_eff + CNT_W'(1);
                sum_next   = sum_eff + SUM_W'(val);
            end
            else if (do_replace)
            begin
                ctrl.op  = OP_REPLACE;
                sum_next = sum_eff - SUM_W'(cell_out[0].value) + SUM_W'(val);
            end
        end
    end

    // sorted value chain
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        cell_link_t left_in;
        cell_link_t right_in;
        if (i == 0)
        begin : g_head
            assign left_in = '{valid: 1'b1, le: 1'b1, value: '0};
        end
        else
        begin : g_mid_l
            assign left_in = cell_out[i-1];
        end
        if (i == MAX_K - 1)
        begin : g_tail
            assign right_in = '{valid: 1'b0, le: 1'b0, value: '0};
        end
        else
        begin : g_mid_r
            assign right_in = cell_out[i+1];
        end
        tks_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .from_left  (left_in),
            .from_right (right_in),
            .to_nbr     (cell_out[i])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KCFG_W'(1);
            count_reg      <= '0;
            sum_reg        <= '0;
            snap_reg       <= '0;
            prev_key_reg   <= '0;
            have_prev_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                keep_count_reg <= cfg_data;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            snap_reg  <= snap_next;
            if (s_accept)
            begin
                prev_key_reg  <= key;
                have_prev_reg <= 1'b1;
            end
            if (s_accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s_accept)
            m_tdata_reg <= M_TDATA_W'({best, idx});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // cell 0 is occupied exactly when the store is not empty, unless a set start hides it
    assign head_ok = ctrl.clear | ((count_reg != '0) == cell_out[0].valid);

    // checks
`include "top_k_sum_of_smaller_keys_assert.svh"

    `TKS_ASSERT_ALWAYS(a_count_bound, (32'(count_reg) <= 32'(MAX_K)), "store count above chain length")
    `TKS_ASSERT_ALWAYS(a_head_valid, head_ok, "cell 0 occupancy disagrees with count")
    `TKS_ASSERT_NEXT(a_set_start, (s_accept && first), (m_tvalid && m_tdata[IDX_W+BEST_W-1:IDX_W] == '0), "set start must answer a zero sum")
    `TKS_ASSERT_NEXT(a_count_keff, (s_accept && do_append), (count_reg <= keff), "store grew beyond k")

endmodule

@@ sv/tks_cell.sv @@
// ----------------------------------------------------------------------------
// tks_cell
// one slot of the sorted value chain, ascending from cell 0 (the minimum)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tks_cell import tks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  cell_link_t  from_left,
    input  cell_link_t  from_right,
    output cell_link_t  to_nbr
);

    logic             valid_reg;
    logic             valid_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             valid_eff;
    logic             le;

    // a set start makes every slot empty
    assign valid_eff = valid_reg & ~ctrl.clear;
    assign le        = valid_eff & (value_reg <= ctrl.value);

    assign to_nbr.valid = valid_eff;
    assign to_nbr.le    = le;
    assign to_nbr.value = value_reg;

    // insertion: append shifts larger values up, replace drops cell 0 and shifts down
    always_comb
    begin
        valid_next = valid_eff;
        value_next = value_reg;
        case (ctrl.op)
            OP_APPEND:
            begin
                valid_next = valid_eff | from_left.valid;
                if (!le)
                begin
                    if (from_left.le)
                        value_next = ctrl.value;
                    else
                        value_next = from_left.value;
                end
            end
            OP_REPLACE:
            begin
                if (from_right.le)
                    value_next = from_right.value;
                else if (le)
                    value_next = ctrl.value;
            end
            default:
            begin
                valid_next = valid_eff;
            end
        endcase
    end

    // slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // slot value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ bench/tks_checker.sv @@
// ----------------------------------------------------------------------------
// tks_checker
// watches the item, result and k-write channels of the running top-k sum
// block, predicts the sum of the k largest earlier values with a smaller key
// for every accepted item request, and compares each result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tks_checker import tks_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // item_key, item_value, item_index
    input  logic [0:0]            s_tuser,   // first_of_set
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // result_index, best_sum, zero pad
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [KCFG_W-1:0]     cfg_data,  // keep_count
    output int                    error_count,
    output int                    outstanding
);

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [BEST_W-1:0] sum;
    } sum_result_t;

    // shadow of the block state
    logic [VAL_W-1:0]  held_vals [MAX_K];
    int                held_count;
    logic [SUM_W-1:0]  top_sum;
    logic [SUM_W-1:0]  group_sum;
    logic [KEY_W-1:0]  last_key;
    logic              key_seen;
    logic [KCFG_W-1:0] k_reg;

    sum_result_t       sum_queue [$];
    int                errs;

    // drop all kept values and sums
    task automatic clear_set();
        held_count = 0;
        top_sum    = '0;
        group_sum  = '0;
        last_key   = '0;
        key_seen   = 1'b0;
    endtask

    // expected result of one item, then the value goes into the store
    task automatic predict_item(input logic first, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] raw_val,
                                input logic [IDX_W-1:0] idx);
        sum_result_t      r;
        int               keff;
        int               pos;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] mn;
        keff = (k_reg > MAX_K) ? MAX_K : int'(k_reg);
        v = raw_val & VALUE_MASK;
        if (first)
            clear_set();
        // a key change opens a new group with a fresh snapshot
        if (!key_seen || key != last_key)
        begin
            group_sum = top_sum;
            last_key  = key;
            key_seen  = 1'b1;
        end
        r.idx = idx;
        r.sum = (group_sum > SUM_W'(BEST_MAX)) ? BEST_MAX : group_sum[BEST_W-1:0];
        sum_queue.push_back(r);
        // append while below k, else replace the minimum if beaten
        if (held_count < keff)
        begin
            held_vals[held_count] = v;
            held_count++;
            top_sum = top_sum + SUM_W'(v);
        end
        else if (held_count != 0)
        begin
            pos = 0;
            mn  = held_vals[0];
            for (int i = 1; i < held_count; i++)
            begin
                if (held_vals[i] < mn)
                begin
                    mn  = held_vals[i];
                    pos = i;
                end
            end
            if (v > mn)
            begin
                held_vals[pos] = v;
                top_sum = top_sum - SUM_W'(mn) + SUM_W'(v);
            end
        end
    endtask

    // compare one result request with the oldest expectation
    task automatic compare_result(input logic [M_TDATA_W-1:0] data);
        sum_result_t       r;
        logic [IDX_W-1:0]  got_idx;
        logic [BEST_W-1:0] got_sum;
        got_idx = data[IDX_W-1:0];
        got_sum = data[IDX_W +: BEST_W];
        if (sum_queue.size() == 0)
        begin
            errs++;
            $display("%0t: unexpected result, expected none, actual index %0d sum %0d",
                     $time, got_idx, got_sum);
        end
        else
        begin
            r = sum_queue.pop_front();
            if (got_idx !== r.idx)
            begin
                errs++;
                $display("%0t: result_index mismatch, expected %0d, actual %0d",
                         $time, r.idx, got_idx);
            end
            if (got_sum !== r.sum)
            begin
                errs++;
                $display("%0t: best_sum mismatch (index %0d), expected %0d, actual %0d",
                         $time, r.idx, r.sum, got_sum);
            end
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_set();
            k_reg = KCFG_W'(1);
            sum_queue.delete();
            errs = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                k_reg = cfg_data;
            if (s_tvalid && s_tready)
                predict_item(s_tuser[0], s_tdata[KEY_W-1:0], s_tdata[KEY_W +: VAL_W],
                             s_tdata[KEY_W+VAL_W +: IDX_W]);
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
        end
        error_count <= errs;
        outstanding <= sum_queue.size();
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the running top-k sum block: directed corner
// items, then random sorted data sets with noise under several k settings,
// random idling on both sides, one long result stall and drain pauses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tks_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_GOAL   = 1850;
    localparam int HOLD_CYCLES = 300;
    localparam logic [VAL_W-1:0] V_MAX = {VAL_W{1'b1}};
    localparam logic [KEY_W-1:0] K_MAX = {KEY_W{1'b1}};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // item_key, item_value, item_index
    logic [0:0]            s_tuser;   // first_of_set
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // result_index, best_sum, zero pad
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [KCFG_W-1:0]     cfg_data;  // keep_count

    int  error_count;
    int  outstanding;
    int  cycle_count;
    int  items_sent;
    bit  steady;
    bit  hold_req;

    top_k_sum_of_smaller_keys dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tks_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int wait_cycles;
        m_tready <= 1'b0;
        forever
        begin
            wait_cycles = steady ? 0 : $urandom_range(0, 3);
            if (hold_req)
            begin
                wait_cycles += HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // offer one item request after a random gap, wait for acceptance
    task automatic send_item(input logic first, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] idx);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {idx, val, key};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // write k while the block is idle
    task automatic set_keep(input logic [KCFG_W-1:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 3))
            0:       return VAL_W'($urandom_range(0, 15));
            1:       return V_MAX - VAL_W'($urandom_range(0, 15));
            default: return VAL_W'($urandom());
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] step_key(input logic [KEY_W-1:0] key);
        int inc;
        int nk;
        case ($urandom_range(0, 4))
            0, 1:    inc = 0;
            2:       inc = 1;
            3:       inc = $urandom_range(1, 7);
            default: inc = $urandom_range(1, 4096);
        endcase
        nk = int'(key) + inc;
        return (nk > int'(K_MAX)) ? K_MAX : KEY_W'(nk);
    endfunction

    // stimulus
    initial
    begin
        int k_plan [12];
        int phase;
        int target;
        int made;
        int len;
        bit first;
        logic [KEY_W-1:0] key;

        k_plan      = '{2, 127, 0, 64, 3, 1, 5, 64, 17, 96, 40, 1};
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        items_sent  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: k of one after reset, extremes, shared group, equal values
        send_item(1'b1, '0, V_MAX, '0);
        send_item(1'b0, '0, '0, {IDX_W{1'b1}});
        send_item(1'b0, 20'd1, 20'd7, 16'd1);
        send_item(1'b0, 20'd1, V_MAX, 16'd2);
        send_item(1'b0, K_MAX, 20'd3, 16'd3);
        // unsorted key opens a new group
        send_item(1'b0, 20'd2, 20'd1, 16'd4);
        // new set clears the store
        send_item(1'b1, K_MAX, 20'd10, 16'd5);
        send_item(1'b0, K_MAX, 20'd20, 16'd6);
        send_item(1'b0, K_MAX, 20'd20, 16'd7);
        drain();

        // k lowered to zero in the middle of a set, then a zero-k set
        set_keep('0);
        send_item(1'b0, K_MAX, 20'd30, 16'd8);
        send_item(1'b0, '0, 20'd40, 16'd9);
        send_item(1'b1, 20'd5, 20'd50, 16'd10);
        send_item(1'b0, 20'd6, 20'd60, 16'd11);
        drain();

        // k above the store size saturates
        set_keep({KCFG_W{1'b1}});
        send_item(1'b1, 20'd0, V_MAX, 16'd12);
        send_item(1'b0, 20'd1, V_MAX, 16'd13);
        send_item(1'b0, 20'd1, 20'd1, 16'd14);
        send_item(1'b0, 20'd2, V_MAX, 16'd15);
        send_item(1'b0, 20'd3, '0, 16'd16);
        send_item(1'b0, K_MAX, 20'd9, 16'd17);
        drain();

        // random phases, each with its own k
        items_sent = 0;
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            set_keep((phase < 12) ? KCFG_W'(k_plan[phase]) : KCFG_W'($urandom_range(0, 127)));
            steady = (phase % 4 == 2);
            target = $urandom_range(120, 190);
            made = 0;
            // the first set may carry over from the previous phase
            first = ($urandom_range(0, 3) != 0);
            key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom()) : KEY_W'($urandom_range(0, 255));
            while (made < target)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 40);
                for (int j = 0; j < len && made < target; j++)
                begin
                    if (phase == 3 && made == 40)
                        hold_req = 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        // noise: out-of-order key, sometimes a stray set start
                        send_item(($urandom_range(0, 7) == 0), KEY_W'($urandom()),
                                  draw_value(), IDX_W'($urandom()));
                    else
                    begin
                        if (j > 0)
                            key = step_key(key);
                        send_item(first, key, draw_value(), IDX_W'($urandom()));
                    end
                    first = 1'b0;
                    made++;
                end
                first = 1'b1;
                key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom())
                                                  : KEY_W'($urandom_range(0, 255));
            end
            drain();
            phase++;
        end

        // settle and give the verdict
        steady = 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/tks_pkg.sv
sv/tks_cell.sv
sv/top_k_sum_of_smaller_keys.sv
bench/tks_checker.sv
bench/testbench.sv
